// ----- src/jrmq_pkg.sv -----
// ----------------------------------------------------------------------------
// jrmq_pkg
// Shared types and constants of the joystick range map quantizer.
// ----------------------------------------------------------------------------
package jrmq_pkg;

  // default converter span
  localparam int AdcLowDefault  = 0;
  localparam int AdcHighDefault = 255;

  localparam int ChW     = 2;
  localparam int SampleW = 8;
  localparam int PosW    = 10;
  localparam int StepW   = 8;
  localparam int OfsW    = 8;
  localparam int QuoW    = 20;   // magnitude of the mapping numerator
  localparam int ApbAw   = 5;
  localparam int ApbDw   = 32;

  // channel codes
  localparam logic [ChW-1:0] CH_HORIZONTAL = 2'd0;
  localparam logic [ChW-1:0] CH_VERTICAL   = 2'd1;
  localparam logic [ChW-1:0] CH_LEFT       = 2'd2;
  localparam logic [ChW-1:0] CH_RIGHT      = 2'd3;

  typedef enum logic [2:0] {
    REG_JOY_LO = 3'd0,
    REG_JOY_HI = 3'd1,
    REG_SLD_LO = 3'd2,
    REG_SLD_HI = 3'd3,
    REG_STEP   = 3'd4,
    REG_OFS_H  = 3'd5,
    REG_OFS_V  = 3'd6
  } reg_idx_e;

  localparam logic [PosW-1:0]  JOY_LO_RST = 10'h39C;  // -100
  localparam logic [PosW-1:0]  JOY_HI_RST = 10'd100;
  localparam logic [PosW-1:0]  SLD_LO_RST = 10'd0;
  localparam logic [PosW-1:0]  SLD_HI_RST = 10'd100;
  localparam logic [StepW-1:0] STEP_RST   = 8'd5;
  localparam logic [OfsW-1:0]  OFS_RST    = 8'd0;

  typedef struct packed {
    logic signed [PosW-1:0] joy_lo;
    logic signed [PosW-1:0] joy_hi;
    logic signed [PosW-1:0] sld_lo;
    logic signed [PosW-1:0] sld_hi;
    logic [StepW-1:0]       step;
    logic signed [OfsW-1:0] ofs_h;
    logic signed [OfsW-1:0] ofs_v;
  } cfg_t;

  typedef struct packed {
    logic load;     // capture word, add offset
    logic mul;      // form products
    logic num;      // sum numerator, capture its sign and magnitude
    logic take_q;   // capture mapped value
    logic quant;    // end tests, start step remainder
    logic take_r;   // form stepped value
    logic finish;   // write result word and held value
  } ctrl_cmd_t;

  typedef struct packed {
    logic div_done;
    logic den_zero;
    logic snap;
    logic out_space;
  } ctrl_sts_t;

endpackage

// ----- src/jrmq_in_if.sv -----
// ----------------------------------------------------------------------------
// jrmq_in_if
// Sample channel: one converter word tagged with its channel.
// ----------------------------------------------------------------------------
interface jrmq_in_if;
  logic                            valid;
  logic                            ready;
  logic [jrmq_pkg::ChW-1:0]        channel;
  logic [jrmq_pkg::SampleW-1:0]    sample;

  modport source (output valid, output channel, output sample, input ready);
  modport sink   (input valid, input channel, input sample, output ready);
endinterface

// ----- src/jrmq_out_if.sv -----
// ----------------------------------------------------------------------------
// jrmq_out_if
// Position channel: new held value and the channel it belongs to.
// ----------------------------------------------------------------------------
interface jrmq_out_if;
  logic                             valid;
  logic                             ready;
  logic signed [jrmq_pkg::PosW-1:0] position;
  logic [jrmq_pkg::ChW-1:0]         channel_echo;

  modport source (output valid, output position, output channel_echo, input ready);
  modport sink   (input valid, input position, input channel_echo, output ready);
endinterface

// ----- src/jrmq_regs.sv -----
// ----------------------------------------------------------------------------
// jrmq_regs
// APB register file holding output ranges, step size and axis offsets.
// ----------------------------------------------------------------------------
module jrmq_regs (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [jrmq_pkg::ApbAw-1:0]  paddr,
  input  logic [jrmq_pkg::ApbDw-1:0]  pwdata,
  output logic [jrmq_pkg::ApbDw-1:0]  prdata,
  output logic                        pready,
  output jrmq_pkg::cfg_t              cfg_o
);

  jrmq_pkg::cfg_t    cfg_q;
  jrmq_pkg::reg_idx_e idx;
  logic              wr_en;

  assign idx    = jrmq_pkg::reg_idx_e'(paddr[4:2]);
  assign wr_en  = psel && penable && pwrite;
  assign pready = 1'b1;
  assign cfg_o  = cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.joy_lo <= jrmq_pkg::JOY_LO_RST;
      cfg_q.joy_hi <= jrmq_pkg::JOY_HI_RST;
      cfg_q.sld_lo <= jrmq_pkg::SLD_LO_RST;
      cfg_q.sld_hi <= jrmq_pkg::SLD_HI_RST;
      cfg_q.step   <= jrmq_pkg::STEP_RST;
      cfg_q.ofs_h  <= jrmq_pkg::OFS_RST;
      cfg_q.ofs_v  <= jrmq_pkg::OFS_RST;
    end else if (wr_en) begin
      case (idx)
        jrmq_pkg::REG_JOY_LO: cfg_q.joy_lo <= pwdata[jrmq_pkg::PosW-1:0];
        jrmq_pkg::REG_JOY_HI: cfg_q.joy_hi <= pwdata[jrmq_pkg::PosW-1:0];
        jrmq_pkg::REG_SLD_LO: cfg_q.sld_lo <= pwdata[jrmq_pkg::PosW-1:0];
        jrmq_pkg::REG_SLD_HI: cfg_q.sld_hi <= pwdata[jrmq_pkg::PosW-1:0];
        jrmq_pkg::REG_STEP:   cfg_q.step   <= pwdata[jrmq_pkg::StepW-1:0];
        jrmq_pkg::REG_OFS_H:  cfg_q.ofs_h  <= pwdata[jrmq_pkg::OfsW-1:0];
        jrmq_pkg::REG_OFS_V:  cfg_q.ofs_v  <= pwdata[jrmq_pkg::OfsW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    case (idx)
      jrmq_pkg::REG_JOY_LO: prdata = {22'd0, cfg_q.joy_lo};
      jrmq_pkg::REG_JOY_HI: prdata = {22'd0, cfg_q.joy_hi};
      jrmq_pkg::REG_SLD_LO: prdata = {22'd0, cfg_q.sld_lo};
      jrmq_pkg::REG_SLD_HI: prdata = {22'd0, cfg_q.sld_hi};
      jrmq_pkg::REG_STEP:   prdata = {24'd0, cfg_q.step};
      jrmq_pkg::REG_OFS_H:  prdata = {24'd0, cfg_q.ofs_h};
      jrmq_pkg::REG_OFS_V:  prdata = {24'd0, cfg_q.ofs_v};
      default:              prdata = '0;
    endcase
  end

endmodule

// ----- src/jrmq_divider.sv -----
// ----------------------------------------------------------------------------
// jrmq_divider
// Unsigned restoring divider giving the remainder, two bits per cycle.
// ----------------------------------------------------------------------------
module jrmq_divider #(
  parameter int unsigned DividendW = 20,   // must be even
  parameter int unsigned DivisorW  = 8
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start_i,
  input  logic [DividendW-1:0] dividend_i,
  input  logic [DivisorW-1:0]  divisor_i,
  output logic [DivisorW-1:0]  rem_o,
  output logic                 done_o
);

  localparam int unsigned Iters = DividendW / 2;
  localparam int unsigned CntW  = $clog2(Iters + 1);

  logic                 busy_q;
  logic                 done_q;
  logic [CntW-1:0]      cnt_q;
  logic [DividendW-1:0] quot_q, quot_d;
  logic [DivisorW-1:0]  rem_q, rem_d;
  logic [DivisorW-1:0]  div_q;

  always_comb begin
    logic [DivisorW:0] t;
    quot_d = quot_q;
    rem_d  = rem_q;
    t      = '0;
    for (int k = 0; k < 2; k++) begin
      t      = {rem_d, quot_d[DividendW-1]};
      quot_d = {quot_d[DividendW-2:0], 1'b0};
      if (t >= {1'b0, div_q}) begin
        rem_d     = DivisorW'(t - {1'b0, div_q});
        quot_d[0] = 1'b1;
      end else begin
        rem_d = t[DivisorW-1:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= CntW'(Iters);
      end else if (busy_q) begin
        cnt_q <= cnt_q - CntW'(1);
        if (cnt_q == CntW'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quot_q <= dividend_i;
      rem_q  <= '0;
      div_q  <= divisor_i;
    end else if (busy_q) begin
      quot_q <= quot_d;
      rem_q  <= rem_d;
    end
  end

  assign rem_o  = rem_q;
  assign done_o = done_q;

`ifndef SYNTH
  a_no_restart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i |-> !busy_q)
    else $error("divider restarted while busy");
`endif

endmodule

// ----- src/jrmq_datapath.sv -----
// ----------------------------------------------------------------------------
// jrmq_datapath
// Offset, linear map, end snap and step quantizer with held values.
// ----------------------------------------------------------------------------
module jrmq_datapath #(
  parameter int AdcLow  = jrmq_pkg::AdcLowDefault,
  parameter int AdcHigh = jrmq_pkg::AdcHighDefault
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  jrmq_pkg::cfg_t                   cfg_i,
  input  jrmq_pkg::ctrl_cmd_t              cmd_i,
  output jrmq_pkg::ctrl_sts_t              sts_o,
  input  logic [jrmq_pkg::ChW-1:0]         in_channel_i,
  input  logic [jrmq_pkg::SampleW-1:0]     in_sample_i,
  input  logic                             out_ready_i,
  output logic                             out_valid_o,
  output logic signed [jrmq_pkg::PosW-1:0] out_position_o,
  output logic [jrmq_pkg::ChW-1:0]         out_channel_o
);

  localparam int PosW   = jrmq_pkg::PosW;
  localparam int QuoW   = jrmq_pkg::QuoW;
  localparam int NumW   = QuoW + 1;
  localparam int RecipW = QuoW + 1;

  localparam int Den    = AdcHigh - AdcLow;
  localparam int DenAbs = (Den < 0) ? -Den : Den;
  localparam bit DenZero = (Den == 0);
  localparam bit DenNeg  = (Den < 0);
  localparam logic signed [8:0] DEN_S   = 9'(Den);

  // reciprocal rounded up: exact floor quotient for any QuoW-bit numerator
  localparam int     DenDiv   = DenZero ? 1 : DenAbs;
  localparam int     DenL     = $clog2(DenDiv);
  localparam int     Shift    = QuoW + DenL;
  localparam longint RecipVal = ((longint'(1) << Shift) + longint'(DenDiv) - 1)
                                / longint'(DenDiv);
  localparam logic [RecipW-1:0] RECIP = RecipW'(RecipVal);

  // word registers
  logic [jrmq_pkg::ChW-1:0]  ch_q;
  logic signed [PosW-1:0]    xa_q;        // sample + offset - AdcLow
  logic signed [18:0]        p1_q;        // lo * span
  logic signed [NumW-1:0]    p2_q;        // xa * (hi - lo)
  logic                      num_neg_q;
  logic [QuoW-1:0]           num_mag_q;
  logic signed [NumW-1:0]    v_q;         // mapped value
  logic                      d_neg_q;
  logic signed [PosW-1:0]    r_q;
  logic signed [PosW-1:0]    pos_q;
  logic [jrmq_pkg::ChW-1:0]  och_q;
  logic                      ovalid_q;
  logic signed [PosW-1:0]    held_q [4];

  logic                      is_joy;
  logic signed [PosW-1:0]    lo, hi;
  logic signed [7:0]         ofs;
  logic signed [10:0]        xa_sum;
  logic signed [10:0]        diff;
  logic signed [18:0]        p1;
  logic signed [NumW-1:0]    p2;
  logic signed [NumW-1:0]    num;
  logic [QuoW-1:0]           num_mag;
  logic [QuoW+RecipW-1:0]    prod;
  logic [QuoW-1:0]           quot;
  logic [7:0]                step_eff;
  logic signed [10:0]        hi_m, lo_p;
  logic                      snap_hi, snap_lo;
  logic signed [10:0]        d;
  logic [9:0]                d_mag;
  logic signed [10:0]        r_full;
  logic signed [NumW-1:0]    q_s;

  logic                      div_start;
  logic [7:0]                div_rem;
  logic                      div_done;

  assign is_joy = (ch_q == jrmq_pkg::CH_HORIZONTAL) || (ch_q == jrmq_pkg::CH_VERTICAL);
  assign lo     = is_joy ? cfg_i.joy_lo : cfg_i.sld_lo;
  assign hi     = is_joy ? cfg_i.joy_hi : cfg_i.sld_hi;

  always_comb begin
    case (in_channel_i)
      jrmq_pkg::CH_HORIZONTAL: ofs = cfg_i.ofs_h;
      jrmq_pkg::CH_VERTICAL:   ofs = cfg_i.ofs_v;
      default:                 ofs = '0;
    endcase
  end

  assign xa_sum = $signed({3'b000, in_sample_i}) + 11'(ofs) - $signed(11'(AdcLow));
  assign diff   = 11'(hi) - 11'(lo);
  assign p1     = lo * DEN_S;
  assign p2     = xa_q * diff;
  assign num    = NumW'(p1_q) + p2_q;
  assign num_mag = num[NumW-1] ? QuoW'(-num) : num[QuoW-1:0];

  // map quotient by reciprocal multiply
  assign prod = num_mag_q * RECIP;
  assign quot = QuoW'(prod >> Shift);

  assign step_eff = (cfg_i.step == '0) ? 8'd1 : cfg_i.step;
  assign hi_m     = 11'(hi) - $signed({3'b000, step_eff});
  assign lo_p     = 11'(lo) + $signed({3'b000, step_eff});
  assign snap_hi  = v_q >= NumW'(hi_m);
  assign snap_lo  = v_q <= NumW'(lo_p);

  // away from both ends the mapped value lies within the 10-bit range
  assign d      = v_q[10:0] - 11'(held_q[ch_q]);
  assign d_mag  = d[10] ? 10'(-d) : d[9:0];
  assign r_full = d_neg_q ? (v_q[10:0] + $signed({3'b000, div_rem}))
                          : (v_q[10:0] - $signed({3'b000, div_rem}));

  assign q_s = (num_neg_q ^ DenNeg) ? -$signed({1'b0, quot}) : $signed({1'b0, quot});

  // divider serves the step remainder only
  assign div_start = cmd_i.quant && !(snap_hi || snap_lo);

  jrmq_divider #(
    .DividendW (PosW),
    .DivisorW  (8)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (d_mag),
    .divisor_i  (step_eff),
    .rem_o      (div_rem),
    .done_o     (div_done)
  );

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      ch_q <= in_channel_i;
      xa_q <= xa_sum[PosW-1:0];
    end
    if (cmd_i.mul) begin
      p1_q <= p1;
      p2_q <= p2;
    end
    if (cmd_i.num) begin
      num_neg_q <= num[NumW-1];
      num_mag_q <= num_mag;
      if (DenZero) v_q <= NumW'(lo);
    end
    if (cmd_i.take_q) v_q <= q_s;
    if (cmd_i.quant) begin
      d_neg_q <= d[10];
      if (snap_hi)      r_q <= hi;
      else if (snap_lo) r_q <= lo;
    end
    if (cmd_i.take_r) r_q <= r_full[PosW-1:0];
    if (cmd_i.finish) begin
      pos_q <= r_q;
      och_q <= ch_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ovalid_q <= 1'b0;
      for (int i = 0; i < 4; i++) held_q[i] <= '0;
    end else begin
      if (cmd_i.finish) begin
        ovalid_q     <= 1'b1;
        held_q[ch_q] <= r_q;
      end else if (out_ready_i) begin
        ovalid_q <= 1'b0;
      end
    end
  end

  assign sts_o.div_done  = div_done;
  assign sts_o.den_zero  = DenZero;
  assign sts_o.snap      = snap_hi || snap_lo;
  assign sts_o.out_space = !ovalid_q || out_ready_i;

  assign out_valid_o    = ovalid_q;
  assign out_position_o = pos_q;
  assign out_channel_o  = och_q;

`ifndef SYNTH
  a_held_matches_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.finish |=> (held_q[och_q] == pos_q) && ovalid_q)
    else $error("held value differs from delivered word");
`endif

endmodule

// ----- src/jrmq_ctrl.sv -----
// ----------------------------------------------------------------------------
// jrmq_ctrl
// Sequencer stepping one word through map, divide and quantize.
// ----------------------------------------------------------------------------
module jrmq_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  jrmq_pkg::ctrl_sts_t  sts_i,
  output jrmq_pkg::ctrl_cmd_t  cmd_o
);

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_MUL  = 3'd1;
  localparam logic [2:0] ST_NUM  = 3'd2;
  localparam logic [2:0] ST_DIV  = 3'd3;
  localparam logic [2:0] ST_QNT  = 3'd4;
  localparam logic [2:0] ST_MOD  = 3'd5;
  localparam logic [2:0] ST_FIN  = 3'd6;

  logic [2:0] state_q, state_d;

  assign in_ready_o = (state_q == ST_IDLE);

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = ST_MUL;
        end
      end
      ST_MUL: begin
        cmd_o.mul = 1'b1;
        state_d   = ST_NUM;
      end
      ST_NUM: begin
        cmd_o.num = 1'b1;
        state_d   = sts_i.den_zero ? ST_QNT : ST_DIV;
      end
      ST_DIV: begin
        // reciprocal multiply is combinational on the registered magnitude
        cmd_o.take_q = 1'b1;
        state_d      = ST_QNT;
      end
      ST_QNT: begin
        cmd_o.quant = 1'b1;
        state_d     = sts_i.snap ? ST_FIN : ST_MOD;
      end
      ST_MOD: begin
        if (sts_i.div_done) begin
          cmd_o.take_r = 1'b1;
          state_d      = ST_FIN;
        end
      end
      ST_FIN: begin
        // wait until the output register can take the word
        if (sts_i.out_space) begin
          cmd_o.finish = 1'b1;
          state_d      = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) state_q <= ST_IDLE;
    else         state_q <= state_d;
  end

`ifndef SYNTH
  a_done_when_waiting: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sts_i.div_done |-> (state_q == ST_MOD))
    else $error("divider finished outside a wait state");
  a_finish_has_space: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.finish |-> sts_i.out_space)
    else $error("result written over an untaken word");
  a_accept_starts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> (state_q == ST_MUL) && !in_ready_o)
    else $error("accepted word did not start the sequence");
`endif

endmodule

// ----- src/joystick_range_map_quantizer_top.sv -----
// ----------------------------------------------------------------------------
// joystick_range_map_quantizer_top
// Maps tagged converter samples onto channel ranges and step-quantizes them.
//
//   channel   dir  handshake      word
//   in_i      in   valid/ready    channel, sample
//   out_o     out  valid/ready    position, channel_echo
//   apb       in   psel/penable   registers 0..6 at paddr 4*i
//
// A word is accepted only after the last one finishes: load, products,
// numerator, map quotient (skipped for an empty converter span), quantize,
// step remainder (skipped when the word snaps to a range end) and finish.
// The map quotient comes from a combinational reciprocal multiply; the
// divider retires the step remainder two bits per cycle. Reset sets the held
// values of all four channels to zero. A finished word waits in the output
// register; the sequencer stalls in its last step only while it is full.
// ----------------------------------------------------------------------------
module joystick_range_map_quantizer_top #(
  parameter int AdcLow  = jrmq_pkg::AdcLowDefault,
  parameter int AdcHigh = jrmq_pkg::AdcHighDefault
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  jrmq_in_if.sink                     in_i,
  jrmq_out_if.source                  out_o,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [jrmq_pkg::ApbAw-1:0]  paddr,
  input  logic [jrmq_pkg::ApbDw-1:0]  pwdata,
  output logic [jrmq_pkg::ApbDw-1:0]  prdata,
  output logic                        pready
);

  jrmq_pkg::cfg_t      cfg;
  jrmq_pkg::ctrl_cmd_t cmd;
  jrmq_pkg::ctrl_sts_t sts;

  jrmq_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  jrmq_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_ready_o (in_i.ready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  jrmq_datapath #(
    .AdcLow  (AdcLow),
    .AdcHigh (AdcHigh)
  ) u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_i          (cfg),
    .cmd_i          (cmd),
    .sts_o          (sts),
    .in_channel_i   (in_i.channel),
    .in_sample_i    (in_i.sample),
    .out_ready_i    (out_o.ready),
    .out_valid_o    (out_o.valid),
    .out_position_o (out_o.position),
    .out_channel_o  (out_o.channel_echo)
  );

endmodule

// ----- bench/joystick_range_map_quantizer_top_test.sv -----
// ----------------------------------------------------------------------------
// joystick_range_map_quantizer_top_test
// Self-checking bench for the joystick range map quantizer. Registers go in
// over APB and are read back. Tagged samples go in over the input channel:
// first a short directed list, then random walks per channel under several
// register settings. Each word out is compared with its listed value or a
// software copy of the map, snap and step logic. Both channels idle at random.
// ----------------------------------------------------------------------------
module joystick_range_map_quantizer_top_test;
  timeunit 1ns;
  timeprecision 1ps;

  import jrmq_pkg::*;

  localparam int NumRegs       = 7;
  localparam int UnusedRegIdx  = 7;
  localparam int AdcLow        = AdcLowDefault;
  localparam int AdcHigh       = AdcHighDefault;
  localparam int PosMax        = 2 ** (PosW - 1) - 1;
  localparam int PosMin        = -(2 ** (PosW - 1));
  localparam int SettleCycles  = 40;
  localparam int CycleLimit    = 400000;
  localparam int Phases        = 5;
  localparam int WordsPerPhase = 100;
  localparam int PlanRows      = 28;

  typedef enum logic {ROW_SAMPLE, ROW_WRITE} row_kind_e;

  // sample rows: arg = channel, val = sample; write rows: arg = register, val = data
  typedef struct packed {
    row_kind_e kind;
    int        arg;
    int        val;
    bit        typed;
    int        want;
  } plan_row_t;

  typedef struct packed {
    logic signed [PosW-1:0] position;
    logic [ChW-1:0]         channel;
  } position_word_t;

  plan_row_t plan [PlanRows] = '{
    '{ROW_SAMPLE, CH_HORIZONTAL, 0,    1, -100},
    '{ROW_SAMPLE, CH_HORIZONTAL, 255,  1, 100},
    '{ROW_SAMPLE, CH_LEFT,       0,    1, 0},
    '{ROW_SAMPLE, CH_RIGHT,      255,  1, 100},
    '{ROW_SAMPLE, CH_VERTICAL,   128,  1, 0},
    '{ROW_SAMPLE, CH_VERTICAL,   140,  0, 0},
    '{ROW_SAMPLE, CH_VERTICAL,   120,  0, 0},
    '{ROW_SAMPLE, CH_RIGHT,      100,  0, 0},
    '{ROW_WRITE,  REG_STEP,      0,    0, 0},
    '{ROW_SAMPLE, CH_LEFT,       200,  0, 0},
    '{ROW_SAMPLE, CH_LEFT,       201,  0, 0},
    '{ROW_WRITE,  REG_OFS_H,     127,  0, 0},
    '{ROW_WRITE,  REG_OFS_V,     -128, 0, 0},
    '{ROW_SAMPLE, CH_HORIZONTAL, 255,  1, 100},
    '{ROW_SAMPLE, CH_VERTICAL,   0,    1, -100},
    '{ROW_SAMPLE, CH_HORIZONTAL, 0,    0, 0},
    '{ROW_WRITE,  REG_JOY_LO,    -512, 0, 0},
    '{ROW_WRITE,  REG_JOY_HI,    511,  0, 0},
    '{ROW_WRITE,  REG_STEP,      255,  0, 0},
    '{ROW_SAMPLE, CH_HORIZONTAL, 128,  1, 511},
    '{ROW_SAMPLE, CH_VERTICAL,   128,  1, -512},
    '{ROW_SAMPLE, CH_HORIZONTAL, 0,    0, 0},
    // reversed slider range: every word snaps to an end
    '{ROW_WRITE,  REG_SLD_LO,    300,  0, 0},
    '{ROW_WRITE,  REG_SLD_HI,    -300, 0, 0},
    '{ROW_SAMPLE, CH_LEFT,       128,  0, 0},
    '{ROW_SAMPLE, CH_RIGHT,      0,    0, 0},
    // write to an address past the last register must change nothing
    '{ROW_WRITE,  UnusedRegIdx,  1023, 0, 0},
    '{ROW_SAMPLE, CH_RIGHT,      255,  0, 0}
  };

  logic             clk_i;
  logic             rst_ni;
  logic             psel;
  logic             penable;
  logic             pwrite;
  logic [ApbAw-1:0] paddr;
  logic [ApbDw-1:0] pwdata;
  logic [ApbDw-1:0] prdata;
  logic             pready;

  jrmq_in_if  in_bus ();
  jrmq_out_if out_bus ();

  logic [ApbDw-1:0]       cfg_words [NumRegs];
  logic signed [PosW-1:0] held_pos [4];
  int                     last_sample [4];
  position_word_t         awaited_positions [$];
  int                     err_count = 0;
  int                     cycle_count = 0;
  bit                     calm = 1'b0;

  joystick_range_map_quantizer_top dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .in_i    (in_bus),
    .out_o   (out_bus),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  function automatic void note_error(string msg);
    err_count++;
    if (err_count <= 10) $display("mismatch: %s", msg);
  endfunction

  function automatic bit take_break();
    return !calm && ($urandom_range(99) < 23);
  endfunction

  function automatic int reg_width(int idx);
    if (idx <= REG_SLD_HI) return PosW;
    if (idx == REG_STEP) return StepW;
    return OfsW;
  endfunction

  // map, snap and step one sample; updates the channel's held value
  function automatic logic signed [PosW-1:0] advance_held(logic [ChW-1:0] ch,
                                                          logic [SampleW-1:0] s);
    longint lo, hi, x, step, den, v, d, r;
    x = longint'(s);
    if (ch == CH_HORIZONTAL || ch == CH_VERTICAL) begin
      lo = longint'($signed(cfg_words[REG_JOY_LO][PosW-1:0]));
      hi = longint'($signed(cfg_words[REG_JOY_HI][PosW-1:0]));
      x += longint'($signed(ch == CH_HORIZONTAL ? cfg_words[REG_OFS_H][OfsW-1:0]
                                                : cfg_words[REG_OFS_V][OfsW-1:0]));
    end else begin
      lo = longint'($signed(cfg_words[REG_SLD_LO][PosW-1:0]));
      hi = longint'($signed(cfg_words[REG_SLD_HI][PosW-1:0]));
    end
    step = longint'(cfg_words[REG_STEP][StepW-1:0]);
    if (step == 0) step = 1;
    den = AdcHigh - AdcLow;
    if (den == 0) v = lo;
    else v = (lo * den + (x - AdcLow) * (hi - lo)) / den;
    d = v - longint'(held_pos[ch]);
    // high end is tested first, so a reversed range always snaps
    if (v >= hi - step) r = hi;
    else if (v <= lo + step) r = lo;
    else if (d >= step) r = v - d % step;
    else if (-d >= step) r = v + (-d) % step;
    else r = longint'(held_pos[ch]);
    if (r > PosMax) r = PosMax;
    if (r < PosMin) r = PosMin;
    held_pos[ch] = PosW'(r);
    return held_pos[ch];
  endfunction

  function automatic logic [SampleW-1:0] pick_sample(int ch);
    int s;
    case ($urandom_range(9))
      0: s = $urandom_range(255);
      1: s = $urandom_range(1) ? 255 : 0;
      default: s = last_sample[ch] + int'($urandom_range(20)) - 10;
    endcase
    if (s < 0) s = 0;
    if (s > 255) s = 255;
    last_sample[ch] = s;
    return SampleW'(s);
  endfunction

  task automatic program_reg(int idx, int value);
    logic [ApbDw-1:0] mask;
    logic [ApbDw-1:0] got;
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= ApbAw'(4 * idx);
    pwdata  <= ApbDw'(value);
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    if (idx < NumRegs) begin
      mask = (ApbDw'(1) << reg_width(idx)) - 1;
      cfg_words[idx] = ApbDw'(value) & mask;
      @(posedge clk_i);
      psel   <= 1'b1;
      pwrite <= 1'b0;
      @(posedge clk_i);
      penable <= 1'b1;
      @(posedge clk_i);
      while (!pready) @(posedge clk_i);
      got = prdata;
      psel    <= 1'b0;
      penable <= 1'b0;
      if ((got & mask) != cfg_words[idx])
        note_error($sformatf("register %0d read: expected %0h, got %0h",
                             idx, cfg_words[idx], got & mask));
    end
    @(posedge clk_i);
  endtask

  task automatic push_word(logic [ChW-1:0] ch, logic [SampleW-1:0] s, bit typed, int want);
    position_word_t w;
    while (take_break()) begin
      in_bus.valid <= 1'b0;
      @(posedge clk_i);
    end
    in_bus.valid   <= 1'b1;
    in_bus.channel <= ch;
    in_bus.sample  <= s;
    @(posedge clk_i);
    while (!in_bus.ready) @(posedge clk_i);
    w.channel  = ch;
    w.position = advance_held(ch, s);
    if (typed) w.position = PosW'(want);
    awaited_positions.push_back(w);
  endtask

  task automatic settle();
    in_bus.valid <= 1'b0;
    while (awaited_positions.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic load_settings(int phase);
    int jlo, jhi, slo, shi, stp, oh, ov;
    jlo = -int'($urandom_range(300));
    jhi = int'($urandom_range(1, 300));
    slo = int'($urandom_range(200)) - 100;
    shi = slo + int'($urandom_range(1, 311));
    stp = $urandom_range(1, 24);
    oh  = int'($urandom_range(80)) - 40;
    ov  = int'($urandom_range(80)) - 40;
    case (phase)
      1: begin
        jlo = PosMin;
        jhi = PosMax;
        slo = PosMin;
        shi = PosMax;
        oh  = 127;
        ov  = -128;
      end
      2: stp = 0;
      3: begin
        stp = 255;
        oh  = -128;
        ov  = 127;
        slo = 400;
        shi = -400;
      end
      4: begin
        stp = 1;
        jlo = 200;
        jhi = -200;
      end
      default: ;
    endcase
    program_reg(REG_JOY_LO, jlo);
    program_reg(REG_JOY_HI, jhi);
    program_reg(REG_SLD_LO, slo);
    program_reg(REG_SLD_HI, shi);
    program_reg(REG_STEP, stp);
    program_reg(REG_OFS_H, oh);
    program_reg(REG_OFS_V, ov);
  endtask

  // position channel: check each word taken, then stall at random
  initial begin
    position_word_t w;
    out_bus.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (rst_ni && out_bus.valid && out_bus.ready) begin
        if (awaited_positions.size() == 0) begin
          note_error($sformatf("unexpected word: channel %0d position %0d",
                               out_bus.channel_echo, out_bus.position));
        end else begin
          w = awaited_positions.pop_front();
          if (out_bus.position !== w.position)
            note_error($sformatf("position on channel %0d: expected %0d, got %0d",
                                 w.channel, w.position, out_bus.position));
          if (out_bus.channel_echo !== w.channel)
            note_error($sformatf("channel_echo: expected %0d, got %0d",
                                 w.channel, out_bus.channel_echo));
        end
      end
      out_bus.ready <= !take_break();
    end
  end

  initial begin
    while (cycle_count < CycleLimit) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("joystick_range_map_quantizer_top_test: errors");
    $finish;
  end

  initial begin
    int ch;
    rst_ni         <= 1'b0;
    psel           <= 1'b0;
    penable        <= 1'b0;
    pwrite         <= 1'b0;
    paddr          <= '0;
    pwdata         <= '0;
    in_bus.valid   <= 1'b0;
    in_bus.channel <= '0;
    in_bus.sample  <= '0;
    cfg_words[REG_JOY_LO] = ApbDw'(JOY_LO_RST);
    cfg_words[REG_JOY_HI] = ApbDw'(JOY_HI_RST);
    cfg_words[REG_SLD_LO] = ApbDw'(SLD_LO_RST);
    cfg_words[REG_SLD_HI] = ApbDw'(SLD_HI_RST);
    cfg_words[REG_STEP]   = ApbDw'(STEP_RST);
    cfg_words[REG_OFS_H]  = ApbDw'(OFS_RST);
    cfg_words[REG_OFS_V]  = ApbDw'(OFS_RST);
    foreach (held_pos[i]) held_pos[i] = '0;
    foreach (last_sample[i]) last_sample[i] = 128;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (plan[i]) begin
      if (plan[i].kind == ROW_WRITE) begin
        settle();
        program_reg(plan[i].arg, plan[i].val);
      end else begin
        push_word(ChW'(plan[i].arg), SampleW'(plan[i].val), plan[i].typed, plan[i].want);
      end
    end

    for (int p = 0; p < Phases; p++) begin
      settle();
      load_settings(p);
      calm = (p == 2);
      repeat (WordsPerPhase) begin
        ch = $urandom_range(3);
        push_word(ChW'(ch), pick_sample(ch), 1'b0, 0);
      end
    end
    calm = 1'b0;
    settle();

    if (err_count == 0) begin
      $display("joystick_range_map_quantizer_top_test: clean");
    end else begin
      $display("joystick_range_map_quantizer_top_test: errors");
    end
    $finish;
  end

endmodule
